[design/periodic_task_scheduler_core_macros.svh]
// assertion macros for the periodic task scheduler core
`ifndef PERIODIC_TASK_SCHEDULER_CORE_MACROS_SVH
`define PERIODIC_TASK_SCHEDULER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define PTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pts assertion failed");

// next-cycle implication, checked out of reset
`define PTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pts assertion failed");

`endif

[design/pts_pkg.sv]
// package for the periodic task scheduler core: sizes, codes and request types
`default_nettype none
package pts_pkg;

  localparam int TBL_DEPTH   = 16;
  localparam int MAX_RESULTS = 16;

  localparam int IDX_W  = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TBL_DEPTH + 1);
  localparam int NRES_W = $clog2(MAX_RESULTS + 1);
  localparam int ENT_W  = 64;

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 32;
  localparam int LIM_W  = 5;
  localparam logic [LIM_W-1:0] LIMIT_RESET = 5'd16;
  localparam int REG_TASK_LIMIT = 0;

  localparam logic [2:0] FUNC_TICK  = 3'd0;
  localparam logic [2:0] FUNC_BIND  = 3'd1;
  localparam logic [2:0] FUNC_START = 3'd2;
  localparam logic [2:0] FUNC_STOP  = 3'd3;
  localparam logic [2:0] FUNC_POLL  = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BAD_ID = 2'd2;

  typedef struct packed {
    logic [2:0]  func;
    logic [4:0]  task_id;
    logic [31:0] period;
    logic        enable;
  } pts_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] result_task;
    logic       fired;
    logic       last;
  } pts_rsp_t;

endpackage
`default_nettype wire

[design/pts_ram.sv]
// generic single-write, single-read synchronous ram with registered read data
`default_nettype none
module pts_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[design/pts_cfg.sv]
// apb-style configuration register block holding the task limit
`default_nettype none
module pts_cfg
  import pts_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output logic      [LIM_W-1:0]  task_limit
);

  logic [LIM_W-1:0] limit_r;
  logic [LIM_W-1:0] limit_nxt;
  logic             sel_limit;
  logic             wr_en;

  assign sel_limit = (32'(paddr >> 2) == REG_TASK_LIMIT);
  assign wr_en     = psel && penable && pwrite;

  always_comb begin
    limit_nxt = limit_r;
    if (wr_en && sel_limit) begin
      limit_nxt = pwdata[LIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  assign prdata     = sel_limit ? CFG_DW'(limit_r) : '0;
  assign pready     = 1'b1;
  assign task_limit = limit_r;

endmodule
`default_nettype wire

[design/periodic_task_scheduler_core.sv]
// periodic task scheduler core: command sequencer around the task table ram
//
//  channel   signals                          transfer
//  request   start, busy, in_req              start high while busy low
//  result    out_strobe, out_rsp              one-cycle strobe per result, no back-pressure
//  config    psel, penable, pwrite, paddr...  apb access phase, pready tied high
//
// tick, bind, stop, bad ids, start on an enabled task and poll of an empty table: result in the
//   cycle after accept, busy stays low
// start on a disabled task: busy in the S_START state for the period read-modify-write
// poll: busy through the S_POLL walk and S_FIN, one table entry read per cycle through the ram
//   port, last result in the same cycle that busy drops
// reset is synchronous; no clearing pass, per-entry written bits make unwritten entries
//   read as zero
`default_nettype none
module periodic_task_scheduler_core
  import pts_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire pts_req_t          in_req,
  output logic                   out_strobe,
  output pts_rsp_t               out_rsp,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  `include "periodic_task_scheduler_core_macros.svh"

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_POLL  = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]           state_r,     state_nxt;
  logic [31:0]          tick_r,      tick_nxt;
  logic [CNT_W-1:0]     bound_r,     bound_nxt;
  logic [TBL_DEPTH-1:0] en_r,        en_nxt;
  logic [TBL_DEPTH-1:0] vld_r,       vld_nxt;
  logic [IDX_W-1:0]     eval_idx_r,  eval_idx_nxt;
  logic [NRES_W-1:0]    fire_cnt_r,  fire_cnt_nxt;
  logic [IDX_W-1:0]     pend_idx_r,  pend_idx_nxt;
  logic                 pend_vld_r,  pend_vld_nxt;
  logic                 out_strobe_r, out_strobe_nxt;
  pts_rsp_t             out_rsp_r,   out_rsp_nxt;

  logic [LIM_W-1:0] task_limit;
  logic             req_fire;
  logic [IDX_W-1:0] in_idx;
  logic             id_bad;
  logic             table_full;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENT_W-1:0] ram_rdata;

  logic [31:0] ent_period;
  logic [31:0] ent_last;
  logic [31:0] elapsed;
  logic        due;
  logic        walk_end;

  pts_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .task_limit (task_limit)
  );

  pts_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TBL_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy     = (state_r != S_IDLE);
  assign req_fire = start && !busy;
  assign in_idx   = IDX_W'(in_req.task_id);

  assign id_bad     = (32'(in_req.task_id) >= 32'(task_limit)) ||
                      (32'(in_req.task_id) >= 32'(TBL_DEPTH));
  assign table_full = (32'(bound_r) >= 32'(task_limit)) ||
                      (32'(bound_r) >= 32'(TBL_DEPTH));

  // unwritten entries read as zero
  assign ent_period = vld_r[eval_idx_r] ? ram_rdata[63:32] : '0;
  assign ent_last   = vld_r[eval_idx_r] ? ram_rdata[31:0]  : '0;
  assign elapsed    = tick_r - ent_last;
  assign due        = en_r[eval_idx_r] && (elapsed >= ent_period) &&
                      (32'(fire_cnt_r) < 32'(MAX_RESULTS));
  assign walk_end   = ((32'(eval_idx_r) + 32'd1) >= 32'(bound_r)) ||
                      (due && ((32'(fire_cnt_r) + 32'd1) >= 32'(MAX_RESULTS)));

  always_comb begin
    state_nxt      = state_r;
    tick_nxt       = tick_r;
    bound_nxt      = bound_r;
    en_nxt         = en_r;
    vld_nxt        = vld_r;
    eval_idx_nxt   = eval_idx_r;
    fire_cnt_nxt   = fire_cnt_r;
    pend_idx_nxt   = pend_idx_r;
    pend_vld_nxt   = pend_vld_r;
    out_strobe_nxt = 1'b0;
    out_rsp_nxt    = '{status: ST_OK, result_task: '0, fired: 1'b0, last: 1'b1};
    ram_we         = 1'b0;
    ram_waddr      = eval_idx_r;
    ram_wdata      = '0;
    ram_raddr      = in_idx;

    unique case (state_r)
      S_IDLE: begin
        if (req_fire) begin
          case (in_req.func)
            FUNC_TICK: begin
              tick_nxt       = tick_r + 32'd1;
              out_strobe_nxt = 1'b1;
            end
            FUNC_BIND: begin
              out_strobe_nxt = 1'b1;
              if (table_full) begin
                out_rsp_nxt.status = ST_FULL;
              end else begin
                ram_we                 = 1'b1;
                ram_waddr              = IDX_W'(bound_r);
                ram_wdata              = {in_req.period, tick_r - in_req.period};
                vld_nxt[IDX_W'(bound_r)] = 1'b1;
                en_nxt[IDX_W'(bound_r)]  = in_req.enable;
                bound_nxt              = bound_r + CNT_W'(1);
                out_rsp_nxt.result_task = 4'(bound_r);
              end
            end
            FUNC_START: begin
              if (id_bad) begin
                out_strobe_nxt     = 1'b1;
                out_rsp_nxt.status = ST_BAD_ID;
              end else if (en_r[in_idx]) begin
                out_strobe_nxt = 1'b1;
              end else begin
                eval_idx_nxt = in_idx;
                state_nxt    = S_START;
              end
            end
            FUNC_STOP: begin
              out_strobe_nxt = 1'b1;
              if (id_bad) begin
                out_rsp_nxt.status = ST_BAD_ID;
              end else begin
                en_nxt[in_idx] = 1'b0;
              end
            end
            FUNC_POLL: begin
              if (bound_r == '0) begin
                out_strobe_nxt = 1'b1;
              end else begin
                ram_raddr    = '0;
                eval_idx_nxt = '0;
                fire_cnt_nxt = '0;
                pend_vld_nxt = 1'b0;
                state_nxt    = S_POLL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_START: begin
        ram_we                 = 1'b1;
        ram_wdata              = {ent_period, tick_r - ent_period};
        vld_nxt[eval_idx_r]    = 1'b1;
        en_nxt[eval_idx_r]     = 1'b1;
        out_strobe_nxt         = 1'b1;
        state_nxt              = S_IDLE;
      end
      S_POLL: begin
        // read of the next entry overlaps the write-back of this one
        ram_raddr = eval_idx_r + IDX_W'(1);
        if (due) begin
          ram_we       = 1'b1;
          ram_wdata    = {ent_period, tick_r};
          fire_cnt_nxt = fire_cnt_r + NRES_W'(1);
          pend_idx_nxt = eval_idx_r;
          pend_vld_nxt = 1'b1;
          if (pend_vld_r) begin
            out_strobe_nxt = 1'b1;
            out_rsp_nxt    = '{status: ST_OK, result_task: 4'(pend_idx_r),
                               fired: 1'b1, last: 1'b0};
          end
        end
        eval_idx_nxt = eval_idx_r + IDX_W'(1);
        if (walk_end) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        out_strobe_nxt = 1'b1;
        if (pend_vld_r) begin
          out_rsp_nxt = '{status: ST_OK, result_task: 4'(pend_idx_r),
                          fired: 1'b1, last: 1'b1};
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      tick_r       <= '0;
      bound_r      <= '0;
      en_r         <= '0;
      vld_r        <= '0;
      pend_vld_r   <= 1'b0;
      fire_cnt_r   <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tick_r       <= tick_nxt;
      bound_r      <= bound_nxt;
      en_r         <= en_nxt;
      vld_r        <= vld_nxt;
      pend_vld_r   <= pend_vld_nxt;
      fire_cnt_r   <= fire_cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    eval_idx_r <= eval_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    out_rsp_r  <= out_rsp_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_rsp    = out_rsp_r;

  `PTS_ASSERT_NOW(a_fired_ok, out_strobe && out_rsp.fired, out_rsp.status == ST_OK)
  `PTS_ASSERT_NOW(a_bound_range, 1'b1, 32'(bound_r) <= 32'(TBL_DEPTH))
  `PTS_ASSERT_NOW(a_enabled_written, 1'b1, (en_r & ~vld_r) == '0)
  `PTS_ASSERT_NEXT(a_tick_result, req_fire && (in_req.func == FUNC_TICK),
                   out_strobe && out_rsp.last)

endmodule
`default_nettype wire
